### rtl/dce_pkg.sv
// shared types and constants of the dynamics curve evaluator
package dce_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_DATE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_DATE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_VOLUME   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_VOLUME     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVATURE      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROTRACTION    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAS_TRANSITION = 3'd6;

   localparam logic [24:0] ONE_Q24   = 25'h100_0000;
   localparam logic [24:0] HALF_Q24  = 25'h080_0000;
   localparam logic [22:0] QUART_Q24 = 23'h40_0000;
   localparam logic [16:0] ONE_Q16   = 17'h1_0000;
   localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
   localparam logic [26:0] THREE_Q24 = 27'h300_0000;

   // sequencer states, one-hot
   typedef enum logic [14:0] {
      ST_IDLE = 15'h0001,
      ST_CP1  = 15'h0002,
      ST_CP2  = 15'h0004,
      ST_TT   = 15'h0008,
      ST_MM   = 15'h0010,
      ST_B1   = 15'h0020,
      ST_B2   = 15'h0040,
      ST_B3   = 15'h0080,
      ST_X1   = 15'h0100,
      ST_X2   = 15'h0200,
      ST_POS  = 15'h0400,
      ST_W1   = 15'h0800,
      ST_W2   = 15'h1000,
      ST_W3   = 15'h2000,
      ST_DONE = 15'h4000
   } state_type;

endpackage

### rtl/dynamics_curve_evaluator_unit.sv
// dynamics curve evaluator: bisection on a cubic time curve, smoothstep volume blend
//
// Channels: req_ takes one query date (ticks) per transaction; rsp_ returns one
// transaction per query with the Q8.8 loudness and the Q1.24 curve parameter.
// csr_ writes the transition registers; write them only while the block is idle.
// One 33x33 multiplier is shared by every product under a small sequencer.
// Dates before the start, at the start, at or after the end, or for a constant
// transition go straight to the hand-over. Other dates compute the control points,
// then run up to BISECT_STEPS bisection rounds (7 curve products plus the position
// product that decides the round), then the blend, and then hand over.
// One query is in work at a time; req_tready is high only while the sequencer
// is idle.
// The result sits in an output register, so a new query is taken while a
// result waits; a stalled receiver holds rsp_tvalid and rsp_tdata, and the
// sequencer waits at its end until the output register frees up.
// Reset clears the configuration registers to their defaults (end_date all ones) and empties
// the output register.
module dynamics_curve_evaluator_unit #(
   parameter int unsigned BISECT_STEPS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [31:0]                            req_tdata,   // [31:0] query_date
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [47:0]                            rsp_tdata,   // [15:0] dynamics_value,
                                                               // [40:16] curve_position
   input  logic                                   csr_we,
   input  logic [dce_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [dce_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int unsigned RW = $clog2(BISECT_STEPS + 1);

   // configuration registers
   logic [31:0] start_date_ff, end_date_ff;
   logic [15:0] start_volume_ff, end_volume_ff;
   logic [16:0] curvature_ff;
   logic [17:0] protraction_ff;
   logic        has_transition_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_date_ff     <= '0;
         end_date_ff       <= '1;
         start_volume_ff   <= '0;
         end_volume_ff     <= '0;
         curvature_ff      <= '0;
         protraction_ff    <= '0;
         has_transition_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            dce_pkg::CSR_START_DATE:     start_date_ff     <= csr_wdata;
            dce_pkg::CSR_END_DATE:       end_date_ff       <= csr_wdata;
            dce_pkg::CSR_START_VOLUME:   start_volume_ff   <= csr_wdata[15:0];
            dce_pkg::CSR_END_VOLUME:     end_volume_ff     <= csr_wdata[15:0];
            dce_pkg::CSR_CURVATURE:      curvature_ff      <= csr_wdata[16:0];
            dce_pkg::CSR_PROTRACTION:    protraction_ff    <= csr_wdata[17:0];
            dce_pkg::CSR_HAS_TRANSITION: has_transition_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // saturated curvature and protraction
   logic [16:0] c_sat, c_inv, p_mag, p_op;
   logic        p_nonneg;
   logic [17:0] p_neg;

   always_comb begin
      c_sat    = (curvature_ff > dce_pkg::ONE_Q16) ? dce_pkg::ONE_Q16 : curvature_ff;
      c_inv    = dce_pkg::ONE_Q16 - c_sat;
      p_nonneg = ~protraction_ff[17];
      p_neg    = 18'd0 - protraction_ff;
      if (p_nonneg)
         p_mag = (protraction_ff > {1'b0, dce_pkg::ONE_Q16}) ? dce_pkg::ONE_Q16
                                                             : protraction_ff[16:0];
      else
         p_mag = (p_neg > {1'b0, dce_pkg::ONE_Q16}) ? dce_pkg::ONE_Q16 : p_neg[16:0];
      p_op = p_nonneg ? p_mag : (dce_pkg::ONE_Q16 - p_mag);
   end

   // datapath registers
   dce_pkg::state_type state_ff, state_in;
   logic [24:0]   t_ff, t_in;
   logic [22:0]   step_ff, step_in;
   logic [RW-1:0] round_ff, round_in;
   logic [31:0]   off_ff, off_in, span_ff, span_in;
   logic [32:0]   x1_ff, x1_in, x2_ff, x2_in, x_ff, x_in;
   logic [24:0]   tt_ff, tt_in, mm_ff, mm_in, b3_ff, b3_in, w_ff, w_in;
   logic [26:0]   b1_ff, b1_in, b2_ff, b2_in;
   logic [65:0]   acc_ff, acc_in;
   logic [15:0]   vol_ff, vol_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_vol_ff, rsp_vol_in;
   logic [24:0]   rsp_pos_ff, rsp_pos_in;

   // shared multiplier
   logic [32:0] mul_a, mul_b;
   logic [65:0] product;
   assign product = {33'd0, mul_a} * {33'd0, mul_b};

   logic [24:0] m_val;
   logic [26:0] sm_coef;
   logic [15:0] vdiff;
   logic        vol_up;
   assign m_val   = dce_pkg::ONE_Q24 - t_ff;
   assign sm_coef = dce_pkg::THREE_Q24 - {1'b0, t_ff, 1'b0};
   assign vol_up  = end_volume_ff >= start_volume_ff;
   assign vdiff   = vol_up ? (end_volume_ff - start_volume_ff)
                           : (start_volume_ff - end_volume_ff);

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         dce_pkg::ST_CP1: begin
            mul_a = {16'd0, p_nonneg ? c_inv : c_sat};
            mul_b = {16'd0, p_op};
         end
         dce_pkg::ST_CP2: begin
            mul_a = {16'd0, p_nonneg ? c_sat : c_inv};
            mul_b = {16'd0, p_op};
         end
         dce_pkg::ST_TT, dce_pkg::ST_W1: begin
            mul_a = {8'd0, t_ff};
            mul_b = {8'd0, t_ff};
         end
         dce_pkg::ST_MM: begin
            mul_a = {8'd0, m_val};
            mul_b = {8'd0, m_val};
         end
         dce_pkg::ST_B1: begin
            mul_a = {8'd0, t_ff};
            mul_b = {8'd0, mm_ff};
         end
         dce_pkg::ST_B2: begin
            mul_a = {8'd0, tt_ff};
            mul_b = {8'd0, m_val};
         end
         dce_pkg::ST_B3: begin
            mul_a = {8'd0, tt_ff};
            mul_b = {8'd0, t_ff};
         end
         dce_pkg::ST_X1: begin
            mul_a = x1_ff;
            mul_b = {6'd0, b1_ff};
         end
         dce_pkg::ST_X2: begin
            mul_a = x2_ff;
            mul_b = {6'd0, b2_ff};
         end
         dce_pkg::ST_POS: begin
            mul_a = x_ff;
            mul_b = {1'b0, span_ff};
         end
         dce_pkg::ST_W2: begin
            mul_a = {6'd0, sm_coef};
            mul_b = {8'd0, tt_ff};
         end
         dce_pkg::ST_W3: begin
            mul_a = {17'd0, vdiff};
            mul_b = {8'd0, w_ff};
         end
         default: ;
      endcase
   end

   // per-state derived values
   logic [65:0] x_sum, pos_diff, pos_mag;
   logic [31:0] date;
   logic        constant, accept, out_free, err_small, go_down, last_round;
   logic [15:0] delta;

   assign date       = req_tdata;
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign constant   = (~has_transition_ff && end_volume_ff == 16'd0) ||
                       (start_volume_ff == end_volume_ff);
   assign x_sum      = acc_ff + product + {9'd0, b3_ff, 32'd0};
   assign pos_diff   = product - {2'd0, off_ff, 32'd0};
   assign go_down    = ~pos_diff[65] && (pos_diff != 66'd0);
   assign pos_mag    = pos_diff[65] ? (66'd0 - pos_diff) : pos_diff;
   assign err_small  = pos_mag[65:32] == 34'd0;
   assign last_round = round_ff == RW'(BISECT_STEPS - 1);
   assign delta      = product[39:24];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      step_in      = step_ff;
      round_in     = round_ff;
      off_in       = off_ff;
      span_in      = span_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      x_in         = x_ff;
      tt_in        = tt_ff;
      mm_in        = mm_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      vol_in       = vol_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_vol_in   = rsp_vol_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (rsp_tready)
         rsp_valid_in = 1'b0;
      case (state_ff)
         dce_pkg::ST_IDLE: begin
            if (accept) begin
               off_in   = date - start_date_ff;
               span_in  = end_date_ff - start_date_ff;
               t_in     = dce_pkg::HALF_Q24;
               step_in  = dce_pkg::QUART_Q24;
               round_in = '0;
               vol_in   = start_volume_ff;
               state_in = dce_pkg::ST_CP1;
               if (date < start_date_ff || constant) begin
                  t_in     = '0;
                  state_in = dce_pkg::ST_DONE;
               end else if (date >= end_date_ff) begin
                  t_in     = dce_pkg::ONE_Q24;
                  vol_in   = end_volume_ff;
                  state_in = dce_pkg::ST_DONE;
               end else if (date == start_date_ff) begin
                  t_in     = '0;
                  state_in = dce_pkg::ST_DONE;
               end
            end
         end
         dce_pkg::ST_CP1: begin
            x1_in    = (p_nonneg ? {c_sat, 16'd0} : 33'd0) + product[32:0];
            state_in = dce_pkg::ST_CP2;
         end
         dce_pkg::ST_CP2: begin
            x2_in    = (p_nonneg ? {c_inv, 16'd0} : 33'd0) + product[32:0];
            state_in = dce_pkg::ST_TT;
         end
         dce_pkg::ST_TT: begin
            tt_in    = product[48:24];
            state_in = dce_pkg::ST_MM;
         end
         dce_pkg::ST_MM: begin
            mm_in    = product[48:24];
            state_in = dce_pkg::ST_B1;
         end
         dce_pkg::ST_B1: begin
            b1_in    = 27'(3 * {2'd0, product[48:24]});
            state_in = dce_pkg::ST_B2;
         end
         dce_pkg::ST_B2: begin
            b2_in    = 27'(3 * {2'd0, product[48:24]});
            state_in = dce_pkg::ST_B3;
         end
         dce_pkg::ST_B3: begin
            b3_in    = product[48:24];
            state_in = dce_pkg::ST_X1;
         end
         dce_pkg::ST_X1: begin
            acc_in   = product;
            state_in = dce_pkg::ST_X2;
         end
         dce_pkg::ST_X2: begin
            // clamp X to one
            x_in     = (x_sum[65:24] > {9'd0, dce_pkg::ONE_Q32}) ? dce_pkg::ONE_Q32
                                                                : x_sum[56:24];
            state_in = dce_pkg::ST_POS;
         end
         dce_pkg::ST_POS: begin
            if (err_small) begin
               state_in = dce_pkg::ST_W1;
            end else begin
               t_in     = go_down ? (t_ff - {2'd0, step_ff}) : (t_ff + {2'd0, step_ff});
               step_in  = step_ff >> 1;
               round_in = round_ff + RW'(1);
               state_in = last_round ? dce_pkg::ST_W1 : dce_pkg::ST_TT;
            end
         end
         dce_pkg::ST_W1: begin
            tt_in    = product[48:24];
            state_in = dce_pkg::ST_W2;
         end
         dce_pkg::ST_W2: begin
            w_in     = (product[65:24] > {17'd0, dce_pkg::ONE_Q24}) ? dce_pkg::ONE_Q24
                                                                   : product[48:24];
            state_in = dce_pkg::ST_W3;
         end
         dce_pkg::ST_W3: begin
            vol_in   = vol_up ? (start_volume_ff + delta) : (start_volume_ff - delta);
            state_in = dce_pkg::ST_DONE;
         end
         dce_pkg::ST_DONE: begin
            // hand over once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_vol_in   = vol_ff;
               rsp_pos_in   = t_ff;
               state_in     = dce_pkg::ST_IDLE;
            end
         end
         default: state_in = dce_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dce_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      t_ff       <= t_in;
      step_ff    <= step_in;
      round_ff   <= round_in;
      off_ff     <= off_in;
      span_ff    <= span_in;
      x1_ff      <= x1_in;
      x2_ff      <= x2_in;
      x_ff       <= x_in;
      tt_ff      <= tt_in;
      mm_ff      <= mm_in;
      b1_ff      <= b1_in;
      b2_ff      <= b2_in;
      b3_ff      <= b3_in;
      w_ff       <= w_in;
      acc_ff     <= acc_in;
      vol_ff     <= vol_in;
      rsp_vol_ff <= rsp_vol_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   assign req_tready = state_ff == dce_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_pos_ff, rsp_vol_ff};

endmodule
